FILE: rtl/ipip_pkg.sv
package ipip_pkg;

   localparam int unsigned MAX_INNER_BYTES_DEF = 1480;
   localparam int unsigned QUEUE_DEPTH         = 4;
   localparam int unsigned HDR_BYTES           = 20;

   localparam logic [7:0]  VER_IHL       = 8'h45;
   localparam logic [7:0]  TTL_DEFAULT   = 8'd64;
   localparam logic [7:0]  PROTO_RESET   = 8'd4;
   localparam logic [15:0] CAP_RESET     = 16'd1500;
   localparam logic [15:0] HDR_LEN       = 16'(HDR_BYTES);
   localparam logic [4:0]  HDR_LAST_IDX  = 5'(HDR_BYTES);

   typedef enum logic [1:0] {
      CSR_SRC_ADDR = 2'd0,
      CSR_DST_ADDR = 2'd1,
      CSR_PROTOCOL = 2'd2,
      CSR_CAPACITY = 2'd3
   } ipip_csr_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_PASS = 2'd1,
      MODE_DROP = 2'd2
   } ipip_mode_type;

   typedef enum logic [1:0] {
      ENT_PASS   = 2'd0,
      ENT_REJECT = 2'd1,
      ENT_HEADER = 2'd2
   } ipip_kind_type;

   typedef struct packed {
      logic [7:0]  inner_byte;
      logic        byte_last;
      logic [15:0] packet_len;
      logic [15:0] packet_id;
   } ipip_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       rejected;
   } ipip_rsp_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [15:0] capacity;
   } ipip_cfg_type;

   typedef struct packed {
      ipip_kind_type kind;
      logic [7:0]    data;
      logic          last;
      logic [15:0]   total;
      logic [15:0]   id;
   } ipip_entry_type;

endpackage

FILE: rtl/ipv4_ip_in_ip_encapsulator.sv
// Wraps an inner packet, presented one byte per req transaction, in a 20-byte outer IPv4
// header (version 0x45, total length, id, TTL 64, configured protocol and addresses, header
// checksum). The first byte's transaction also carries packet_len and packet_id. A packet that
// is empty, longer than MAX_INNER_BYTES or whose outer length exceeds the capacity register
// yields a single rsp with rejected and out_last set, and its remaining bytes are discarded.
// Payload bytes pass at one per cycle unless rsp_ready stalls the output; an accepted
// packet's first byte follows its 20 header bytes, sent by the header sequencer in the back
// end. A 4-entry queue between the classifier and the sequencer keeps req_ready high while a
// header is being sent, so up to three further bytes are taken before the input stalls. CSR
// writes take effect in the next cycle and must only happen while no packet is in flight.
module ipv4_ip_in_ip_encapsulator import ipip_pkg::*; #(
   parameter int unsigned MAX_INNER_BYTES = MAX_INNER_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ipip_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ipip_rsp_type rsp_data,
   input  logic         csr_we,
   input  ipip_csr_type csr_addr,
   input  logic [31:0]  csr_wdata
);

   ipip_cfg_type   cfg_ff;
   ipip_entry_type push_entry, head;
   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_addr <= '0;
         cfg_ff.dst_addr <= '0;
         cfg_ff.protocol <= PROTO_RESET;
         cfg_ff.capacity <= CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SRC_ADDR: cfg_ff.src_addr <= csr_wdata;
            CSR_DST_ADDR: cfg_ff.dst_addr <= csr_wdata;
            CSR_PROTOCOL: cfg_ff.protocol <= csr_wdata[7:0];
            CSR_CAPACITY: cfg_ff.capacity <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   ipip_front #(
      .MAX_INNER_BYTES(MAX_INNER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   ipip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   ipip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/ipip_front.sv
module ipip_front import ipip_pkg::*; #(
   parameter int unsigned MAX_INNER_BYTES = MAX_INNER_BYTES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ipip_req_type   req_data,
   input  ipip_cfg_type   cfg,
   input  logic           q_full,
   output logic           q_push,
   output ipip_entry_type q_entry
);

   localparam logic [15:0] MaxLen = 16'(MAX_INNER_BYTES);

   ipip_mode_type mode_ff, mode_in;
   logic          accept;
   logic [16:0]   total_wide;
   logic          reject;

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign total_wide = {1'b0, req_data.packet_len} + {1'b0, HDR_LEN};
   assign reject     = (req_data.packet_len == 16'd0) || (req_data.packet_len > MaxLen) ||
                       (total_wide > {1'b0, cfg.capacity});

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      q_push        = 1'b0;
      q_entry.kind  = ENT_PASS;
      q_entry.data  = req_data.inner_byte;
      q_entry.last  = req_data.byte_last;
      q_entry.total = total_wide[15:0];
      q_entry.id    = req_data.packet_id;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (accept) begin
               q_push = 1'b1;
               if (reject) begin
                  q_entry.kind = ENT_REJECT;
                  mode_in      = req_data.byte_last ? MODE_IDLE : MODE_DROP;
               end else begin
                  q_entry.kind = ENT_HEADER;
                  mode_in      = req_data.byte_last ? MODE_IDLE : MODE_PASS;
               end
            end
         end
         MODE_PASS: begin
            if (accept) begin
               q_push = 1'b1;
               if (req_data.byte_last) begin
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_DROP: begin
            if (accept && req_data.byte_last) begin
               mode_in = MODE_IDLE;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

endmodule

FILE: rtl/ipip_queue.sv
module ipip_queue import ipip_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ipip_entry_type push_entry,
   input  logic           pop,
   output ipip_entry_type head,
   output logic           full,
   output logic           empty
);

   localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   ipip_entry_type          mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]         count_ff, count_in;

   assign full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/ipip_back.sv
module ipip_back import ipip_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ipip_cfg_type   cfg,
   input  ipip_entry_type head,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output ipip_rsp_type   rsp_data
);

   logic         rsp_valid_ff;
   ipip_rsp_type rsp_ff, rsp_in;
   logic [4:0]   idx_ff, idx_in;
   logic [19:0]  acc_ff, acc_in;
   logic         gen;
   logic [15:0]  ck;
   logic [7:0]   hbyte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign gen       = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign ck        = ~acc_ff[15:0];

   always_comb begin
      unique case (idx_ff)
         5'd0:    hbyte = VER_IHL;
         5'd2:    hbyte = head.total[15:8];
         5'd3:    hbyte = head.total[7:0];
         5'd4:    hbyte = head.id[15:8];
         5'd5:    hbyte = head.id[7:0];
         5'd8:    hbyte = TTL_DEFAULT;
         5'd9:    hbyte = cfg.protocol;
         5'd10:   hbyte = ck[15:8];
         5'd11:   hbyte = ck[7:0];
         5'd12:   hbyte = cfg.src_addr[31:24];
         5'd13:   hbyte = cfg.src_addr[23:16];
         5'd14:   hbyte = cfg.src_addr[15:8];
         5'd15:   hbyte = cfg.src_addr[7:0];
         5'd16:   hbyte = cfg.dst_addr[31:24];
         5'd17:   hbyte = cfg.dst_addr[23:16];
         5'd18:   hbyte = cfg.dst_addr[15:8];
         5'd19:   hbyte = cfg.dst_addr[7:0];
         default: hbyte = 8'd0;
      endcase
   end

   // running checksum: eight header words summed in six add steps, then two end-around folds, done before byte 10
   always_comb begin
      unique case (idx_ff)
         5'd0:    acc_in = 20'(head.total) + 20'(head.id) + 20'({VER_IHL, 8'd0});
         5'd1:    acc_in = acc_ff + 20'({TTL_DEFAULT, cfg.protocol});
         5'd2:    acc_in = acc_ff + 20'(cfg.src_addr[31:16]);
         5'd3:    acc_in = acc_ff + 20'(cfg.src_addr[15:0]);
         5'd4:    acc_in = acc_ff + 20'(cfg.dst_addr[31:16]);
         5'd5:    acc_in = acc_ff + 20'(cfg.dst_addr[15:0]);
         5'd6,
         5'd7:    acc_in = 20'(acc_ff[15:0]) + 20'(acc_ff[19:16]);
         default: acc_in = acc_ff;
      endcase
   end

   always_comb begin
      q_pop           = 1'b0;
      idx_in          = idx_ff;
      rsp_in          = rsp_ff;
      rsp_in.out_byte = head.data;
      rsp_in.out_last = head.last;
      rsp_in.rejected = 1'b0;
      unique case (head.kind)
         ENT_PASS: begin
            q_pop = gen;
         end
         ENT_REJECT: begin
            q_pop           = gen;
            rsp_in.out_byte = 8'd0;
            rsp_in.out_last = 1'b1;
            rsp_in.rejected = 1'b1;
         end
         ENT_HEADER: begin
            if (idx_ff == HDR_LAST_IDX) begin
               q_pop  = gen;
               idx_in = '0;
            end else begin
               idx_in          = idx_ff + 1'b1;
               rsp_in.out_byte = hbyte;
               rsp_in.out_last = 1'b0;
            end
         end
         default: q_pop = gen;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (gen) begin
            rsp_valid_ff <= 1'b1;
            if (head.kind == ENT_HEADER) begin
               idx_ff <= idx_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen) begin
         rsp_ff <= rsp_in;
         if (head.kind == ENT_HEADER) begin
            acc_ff <= acc_in;
         end
      end
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ipip_pkg::*;

   localparam int unsigned MAX_INNER   = MAX_INNER_BYTES_DEF;
   localparam int          STALL_LIMIT = 2000;
   localparam int          SETTLE_CYC  = 40;
   localparam int          HOLD_CYC    = 300;
   localparam int          PHASE_ITEMS = 52;
   localparam int          N_PHASES    = 6;
   localparam int          N_DIR       = 28;

   typedef struct packed {
      bit           is_write;
      ipip_csr_type addr;
      logic [31:0]  wdata;
      logic [7:0]   inner_byte;
      logic         byte_last;
      logic [15:0]  packet_len;
      logic [15:0]  packet_id;
      bit           reject_due;
   } dir_row_type;

   typedef struct {
      bit           typed;
      ipip_rsp_type rsp;
   } typed_rsp_type;

   localparam ipip_rsp_type REJECT_RSP = '{out_byte: 8'h00, out_last: 1'b1, rejected: 1'b1};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   ipip_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   ipip_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   ipip_csr_type csr_addr = CSR_SRC_ADDR;
   logic [31:0]  csr_wdata = '0;

   ipip_cfg_type  wrap_cfg = '{src_addr: 32'h0, dst_addr: 32'h0,
                               protocol: PROTO_RESET, capacity: CAP_RESET};
   ipip_mode_type wrap_mode = MODE_IDLE;

   ipip_rsp_type  outer_bytes_due [$];
   ipip_rsp_type  step_bytes [$];
   typed_rsp_type typed_rsp_q [$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_left      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int productive_items = 0;

   dir_row_type dir_rows [N_DIR] = '{
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h00, 1'b1, 16'd0,     16'h0000, 1'b1},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'hFF, 1'b0, 16'd1481,  16'hFFFF, 1'b1},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h12, 1'b0, 16'd5,     16'h1234, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h34, 1'b1, 16'd0,     16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'hFF, 1'b1, 16'hFFFF,  16'hFFFF, 1'b1},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h00, 1'b1, 16'd1,     16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'hA5, 1'b0, 16'd1480,  16'hFFFF, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h5A, 1'b1, 16'd0,     16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'hFF, 1'b0, 16'd2,     16'h8001, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h00, 1'b0, 16'hFFFF,  16'hFFFF, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h80, 1'b1, 16'h0000,  16'h0000, 1'b0},
      '{1'b1, CSR_CAPACITY, 32'd100,       8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b1, CSR_SRC_ADDR, 32'hFFFF_FFFF, 8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b1, CSR_DST_ADDR, 32'hFFFF_FFFF, 8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b1, CSR_PROTOCOL, 32'h0000_00FF, 8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h01, 1'b1, 16'd81,    16'h7FFF, 1'b1},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'hFE, 1'b1, 16'd80,    16'h7FFF, 1'b0},
      '{1'b1, CSR_CAPACITY, 32'd0,         8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h00, 1'b1, 16'd1,     16'h0000, 1'b1},
      '{1'b1, CSR_CAPACITY, 32'd21,        8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h77, 1'b1, 16'd1,     16'hABCD, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h77, 1'b1, 16'd2,     16'hABCD, 1'b1},
      '{1'b1, CSR_CAPACITY, 32'h0000_FFFF, 8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b1, CSR_SRC_ADDR, 32'h0,         8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b1, CSR_DST_ADDR, 32'h0,         8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b1, CSR_PROTOCOL, 32'h0,         8'h00, 1'b0, 16'd0, 16'h0000, 1'b0},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'hC3, 1'b1, 16'd1481,  16'h0001, 1'b1},
      '{1'b0, CSR_SRC_ADDR, 32'h0, 8'h3C, 1'b1, 16'd1480,  16'hFFFE, 1'b0}
   };

   ipv4_ip_in_ip_encapsulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Outer bytes caused by one inner-byte transaction, left in step_bytes.
   task automatic wrap_inner_byte(input ipip_req_type r);
      logic [7:0]  hdr [HDR_BYTES];
      int unsigned acc;
      int unsigned total;
      logic [15:0] ck;
      step_bytes.delete();
      case (wrap_mode)
         MODE_PASS: begin
            step_bytes.push_back(ipip_rsp_type'{r.inner_byte, r.byte_last, 1'b0});
            if (r.byte_last) wrap_mode = MODE_IDLE;
         end
         MODE_DROP: begin
            if (r.byte_last) wrap_mode = MODE_IDLE;
         end
         default: begin
            total = HDR_BYTES + r.packet_len;
            if (r.packet_len == 0 || r.packet_len > MAX_INNER || total > wrap_cfg.capacity) begin
               step_bytes.push_back(REJECT_RSP);
               wrap_mode = r.byte_last ? MODE_IDLE : MODE_DROP;
            end else begin
               foreach (hdr[k]) hdr[k] = 8'h00;
               hdr[0]  = VER_IHL;
               hdr[2]  = total[15:8];
               hdr[3]  = total[7:0];
               hdr[4]  = r.packet_id[15:8];
               hdr[5]  = r.packet_id[7:0];
               hdr[8]  = TTL_DEFAULT;
               hdr[9]  = wrap_cfg.protocol;
               hdr[12] = wrap_cfg.src_addr[31:24];
               hdr[13] = wrap_cfg.src_addr[23:16];
               hdr[14] = wrap_cfg.src_addr[15:8];
               hdr[15] = wrap_cfg.src_addr[7:0];
               hdr[16] = wrap_cfg.dst_addr[31:24];
               hdr[17] = wrap_cfg.dst_addr[23:16];
               hdr[18] = wrap_cfg.dst_addr[15:8];
               hdr[19] = wrap_cfg.dst_addr[7:0];
               acc = 0;
               for (int k = 0; k < HDR_BYTES; k += 2) acc += {hdr[k], hdr[k + 1]};
               while (acc >> 16) acc = (acc & 32'h0000_FFFF) + (acc >> 16);
               ck = ~acc[15:0];
               hdr[10] = ck[15:8];
               hdr[11] = ck[7:0];
               foreach (hdr[k]) step_bytes.push_back(ipip_rsp_type'{hdr[k], 1'b0, 1'b0});
               step_bytes.push_back(ipip_rsp_type'{r.inner_byte, r.byte_last, 1'b0});
               wrap_mode = r.byte_last ? MODE_IDLE : MODE_PASS;
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input ipip_rsp_type want,
                                  input ipip_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected byte %02h last %b rej %b, got byte %02h last %b rej %b",
                  $realtime, what, want.out_byte, want.out_last, want.rejected,
                  got.out_byte, got.out_last, got.rejected);
   endtask

   task automatic check_outer_byte(input ipip_rsp_type got);
      ipip_rsp_type want;
      if (outer_bytes_due.size() == 0) begin
         report_mismatch("unexpected transaction", '0, got);
      end else begin
         want = outer_bytes_due.pop_front();
         if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
             got.rejected !== want.rejected)
            report_mismatch("mismatch", want, got);
      end
   endtask

   task automatic take_inner_byte(input ipip_req_type r);
      typed_rsp_type pin;
      pin = typed_rsp_q.pop_front();
      wrap_inner_byte(r);
      if (step_bytes.size() != 0) productive_items++;
      if (pin.typed)
         outer_bytes_due.push_back(pin.rsp);
      else
         foreach (step_bytes[k]) outer_bytes_due.push_back(step_bytes[k]);
   endtask

   // Scoreboard and watchdog; request side first so a same-cycle result sees its prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) take_inner_byte(req_data);
         if (rsp_valid && rsp_ready) check_outer_byte(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic drive_req(input ipip_req_type item, input bit typed, input ipip_rsp_type rsp);
      typed_rsp_q.push_back('{typed, rsp});
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outer_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input ipip_csr_type addr, input logic [31:0] wdata);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= wdata;
      case (addr)
         CSR_SRC_ADDR: wrap_cfg.src_addr = wdata;
         CSR_DST_ADDR: wrap_cfg.dst_addr = wdata;
         CSR_PROTOCOL: wrap_cfg.protocol = wdata[7:0];
         CSR_CAPACITY: wrap_cfg.capacity = wdata[15:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_packet(input int len, input int count);
      ipip_req_type item;
      for (int i = 0; i < count; i++) begin
         item.inner_byte = 8'($urandom_range(255));
         item.byte_last  = (i == count - 1);
         item.packet_len = (i == 0) ? len[15:0] : 16'($urandom_range(65535));
         item.packet_id  = 16'($urandom_range(65535));
         drive_req(item, 1'b0, '0);
      end
   endtask

   task automatic send_random_packet();
      int fit;
      int r;
      int len;
      int count;
      fit = (wrap_cfg.capacity > HDR_BYTES) ? wrap_cfg.capacity - HDR_BYTES : 0;
      if (fit > MAX_INNER) fit = MAX_INNER;
      r = $urandom_range(99);
      if (r < 70 && fit > 0) begin
         len   = $urandom_range(1, (fit < 12) ? fit : 12);
         count = len;
      end else if (r < 80 && fit > 0) begin
         len   = $urandom_range(1, fit);
         count = $urandom_range(1, 8);
      end else if (r < 86) begin
         len   = 0;
         count = $urandom_range(1, 4);
      end else if (r < 92) begin
         len   = $urandom_range(MAX_INNER + 1, 65535);
         count = $urandom_range(1, 4);
      end else if (r < 96 && fit < MAX_INNER) begin
         len   = fit + 1;
         count = $urandom_range(1, 4);
      end else begin
         len   = $urandom_range(65535);
         count = $urandom_range(1, 6);
      end
      send_packet(len, count);
   endtask

   initial begin
      ipip_req_type item;
      int target;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_write) begin
            settle_block();
            write_csr(dir_rows[i].addr, dir_rows[i].wdata);
         end else begin
            item = '{dir_rows[i].inner_byte, dir_rows[i].byte_last,
                     dir_rows[i].packet_len, dir_rows[i].packet_id};
            drive_req(item, dir_rows[i].reject_due, REJECT_RSP);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle_block();
         case (p)
            0: begin
               write_csr(CSR_SRC_ADDR, $urandom());
               write_csr(CSR_DST_ADDR, $urandom());
               write_csr(CSR_PROTOCOL, {16'($urandom_range(16'hFFFF)), 16'h0004});
               write_csr(CSR_CAPACITY, {16'($urandom_range(16'hFFFF)), CAP_RESET});
            end
            1: begin
               write_csr(CSR_SRC_ADDR, 32'hFFFF_FFFF);
               write_csr(CSR_DST_ADDR, 32'h0);
               write_csr(CSR_PROTOCOL, 32'hFFFF_FFFF);
               write_csr(CSR_CAPACITY, 32'hFFFF_FFFF);
            end
            2: begin
               write_csr(CSR_SRC_ADDR, 32'h0);
               write_csr(CSR_DST_ADDR, 32'hFFFF_FFFF);
               write_csr(CSR_PROTOCOL, 32'h0);
               write_csr(CSR_CAPACITY, 32'd100);
            end
            3: begin
               write_csr(CSR_SRC_ADDR, $urandom());
               write_csr(CSR_DST_ADDR, $urandom());
               write_csr(CSR_PROTOCOL, $urandom());
               write_csr(CSR_CAPACITY, {16'($urandom_range(16'hFFFF)),
                                        16'($urandom_range(21, 1600))});
            end
            4: begin
               write_csr(CSR_SRC_ADDR, $urandom());
               write_csr(CSR_DST_ADDR, $urandom());
               write_csr(CSR_PROTOCOL, $urandom());
               write_csr(CSR_CAPACITY, 32'd1500);
            end
            default: begin
               write_csr(CSR_SRC_ADDR, $urandom());
               write_csr(CSR_DST_ADDR, $urandom());
               write_csr(CSR_PROTOCOL, $urandom());
               write_csr(CSR_CAPACITY, 32'd65535);
            end
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         target = productive_items + PHASE_ITEMS;
         if (p == 0) begin
            // receiver blocked while a full packet is offered: input must back up
            hold_left = HOLD_CYC;
            send_packet(40, 40);
         end
         while (productive_items < target) send_random_packet();
      end

      settle_block();
      if (mismatch_count == 0 && outer_bytes_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
rtl/ipip_pkg.sv
rtl/ipip_front.sv
rtl/ipip_queue.sv
rtl/ipip_back.sv
rtl/ipv4_ip_in_ip_encapsulator.sv
sim/testbench.sv
